// ===== rtl/sprite_quad_batcher_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sprite quad batcher assertion macros
// Shared property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_BATCHER_CORE_DEFINES_SVH
`define SPRITE_QUAD_BATCHER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SQB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite quad batcher check failed");

// Next-cycle implication.
`define SQB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite quad batcher check failed");

`endif

// ===== rtl/sqb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite quad batcher package
// Constants of the angle reduction and sine polynomial, and shared types.
// ----------------------------------------------------------------------------
package sqb_pkg;

  localparam logic [14:0] QUARTER   = 15'd5760;
  localparam logic [14:0] FULL_TURN = 15'd23040;

  // For r up to one quarter turn, floor(r * 2^23 / 45) equals
  // r * RECIP_INT + ((r * RECIP_FRAC) >> 24).
  localparam logic [17:0] RECIP_INT  = 18'd186413;
  localparam logic [23:0] RECIP_FRAC = 24'd8575044;

  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569303;
  localparam logic [31:0] C7 = 32'd5026996;
  localparam logic [31:0] C9 = 32'd172273;

  typedef struct packed {
    logic signed [47:0] a;
    logic signed [47:0] b;
    logic signed [47:0] c;
    logic signed [47:0] d;
  } xform_res_t;

endpackage

// ===== rtl/sprite_quad_batcher_core.sv =====
// ----------------------------------------------------------------------------
// Sprite quad batcher core
// Turns one sprite item into four batched vertex items with texture slots.
// ----------------------------------------------------------------------------
// The block takes one item at a time and is not ready until all results of
// that item have left. A textured sprite searches the slot table one slot at
// a time, reading each slot and then comparing it to the id. The sine and the
// cosine each take a reciprocal step for the polynomial argument and six
// steps on the one multiplier, and the four size products take four more
// such steps. The results then go out at one item per cycle while out_tready
// is high. The slot table needs no clearing pass.
`include "sprite_quad_batcher_core_defines.svh"

module sprite_quad_batcher_core #(
  parameter int MAX_QUADS     = 1024,
  parameter int TEXTURE_SLOTS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, size_x, size_y, angle, color_r, color_g, color_b, color_a,
  // use_texture, texture_id
  input  logic [191:0] in_tdata,
  // kind
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // flushed_quads, vert_x, vert_y, tex_u, tex_v, color_rgba, slot_index
  output logic [119:0] out_tdata,
  // is_flush
  output logic         out_tuser,
  output logic         out_tlast
);

  localparam int QW0 = $clog2(MAX_QUADS + 1);
  localparam int CW  = (QW0 > 11) ? QW0 : 11;
  localparam int SW0 = $clog2(TEXTURE_SLOTS + 1);
  localparam int SW  = (SW0 > 5) ? SW0 : 5;
  localparam int AW  = $clog2(TEXTURE_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_CMP, ST_DECIDE, ST_XFORM, ST_FLUSH, ST_VERT
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       qcnt_r;
  logic [SW-1:0]       su_r;
  logic [SW-1:0]       idx_r;
  logic [SW-1:0]       slot_r;
  logic                found_r;
  logic                flush_pend_r;
  logic                end_r;
  logic [1:0]          corner_r;
  logic signed [31:0]  px_r;
  logic signed [31:0]  py_r;
  logic signed [31:0]  szx_r;
  logic signed [31:0]  szy_r;
  logic [14:0]         angle_r;
  logic [31:0]         rgba_r;
  logic                tex_r;
  logic [15:0]         id_r;
  logic [15:0]         slot_mem [TEXTURE_SLOTS];
  logic [15:0]         rd_data_r;
  logic                out_valid_r;
  logic [119:0]        out_data_r;
  logic                out_user_r;
  logic                out_last_r;

  logic                xf_start;
  logic                xf_done;
  sqb_pkg::xform_res_t xf_res;
  logic                need_flush;
  logic                eff_new;
  logic [SW-1:0]       su_base;
  logic [CW-1:0]       qc_base;
  logic                mem_we;
  logic [1:0]          corner_nxt;

  function automatic logic [119:0] vert_data(
    input logic [1:0]          k,
    input sqb_pkg::xform_res_t r,
    input logic signed [31:0]  px,
    input logic signed [31:0]  py,
    input logic [31:0]         rgba,
    input logic [4:0]          slot
  );
    logic               cx;
    logic               cy;
    logic signed [48:0] sx;
    logic signed [48:0] sy;
    logic signed [48:0] rx;
    logic signed [48:0] ry;
    logic [31:0]        vx;
    logic [31:0]        vy;
    cx = (k == 2'd1) || (k == 2'd2);
    cy = k[1];
    sx = (cx ? 49'(r.a) : -49'(r.a)) - (cy ? 49'(r.b) : -49'(r.b));
    sy = (cx ? 49'(r.c) : -49'(r.c)) + (cy ? 49'(r.d) : -49'(r.d));
    rx = (sx + 49'sd32768) >>> 16;
    ry = (sy + 49'sd32768) >>> 16;
    vx = px + rx[31:0];
    vy = py + ry[31:0];
    return {6'd0, slot, rgba, cy, cx, vy, vx, 11'd0};
  endfunction

  sqb_xform u_xform (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (xf_start),
    .angle  (angle_r),
    .size_x (szx_r),
    .size_y (szy_r),
    .done   (xf_done),
    .res    (xf_res)
  );

  assign need_flush = (qcnt_r >= CW'(MAX_QUADS)) ||
                      (tex_r && !found_r && (su_r >= SW'(TEXTURE_SLOTS)));
  assign eff_new    = tex_r && (!found_r || need_flush);
  assign su_base    = need_flush ? SW'(1) : su_r;
  assign qc_base    = need_flush ? '0 : qcnt_r;
  assign mem_we     = (state_r == ST_DECIDE) && eff_new &&
                      (su_base < SW'(TEXTURE_SLOTS));
  assign xf_start   = (state_r == ST_DECIDE);
  assign corner_nxt = corner_r + 2'd1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[su_base[AW-1:0]] <= id_r;
    end
    rd_data_r <= slot_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      qcnt_r       <= '0;
      su_r         <= SW'(1);
      out_valid_r  <= 1'b0;
      flush_pend_r <= 1'b0;
      end_r        <= 1'b0;
      found_r      <= 1'b0;
      corner_r     <= 2'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            px_r    <= in_tdata[31:0];
            py_r    <= in_tdata[63:32];
            szx_r   <= in_tdata[95:64];
            szy_r   <= in_tdata[127:96];
            angle_r <= in_tdata[142:128];
            rgba_r  <= {in_tdata[150:143], in_tdata[158:151],
                        in_tdata[166:159], in_tdata[174:167]};
            tex_r   <= in_tdata[175];
            id_r    <= in_tdata[191:176];
            found_r <= 1'b0;
            slot_r  <= '0;
            idx_r   <= SW'(1);
            if (in_tuser) begin
              out_data_r  <= {109'd0, qcnt_r[10:0]};
              out_user_r  <= 1'b1;
              out_last_r  <= 1'b1;
              out_valid_r <= 1'b1;
              end_r       <= 1'b1;
              qcnt_r      <= '0;
              su_r        <= SW'(1);
              state_r     <= ST_FLUSH;
            end else begin
              end_r   <= 1'b0;
              state_r <= in_tdata[175] ? ST_RD : ST_DECIDE;
            end
          end
        end
        ST_RD: begin
          if ((idx_r >= su_r) || (idx_r >= SW'(TEXTURE_SLOTS))) begin
            state_r <= ST_DECIDE;
          end else begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (rd_data_r == id_r) begin
            found_r <= 1'b1;
            slot_r  <= idx_r;
            state_r <= ST_DECIDE;
          end else begin
            idx_r   <= idx_r + SW'(1);
            state_r <= ST_RD;
          end
        end
        ST_DECIDE: begin
          flush_pend_r <= need_flush;
          out_data_r   <= {109'd0, qcnt_r[10:0]};
          qcnt_r       <= qc_base + CW'(1);
          if (eff_new) begin
            slot_r <= su_base;
            su_r   <= su_base + SW'(1);
          end else begin
            su_r <= su_base;
          end
          state_r <= ST_XFORM;
        end
        ST_XFORM: begin
          if (xf_done) begin
            out_valid_r <= 1'b1;
            corner_r    <= 2'd0;
            if (flush_pend_r) begin
              out_user_r <= 1'b1;
              out_last_r <= 1'b0;
              state_r    <= ST_FLUSH;
            end else begin
              out_data_r <= vert_data(2'd0, xf_res, px_r, py_r, rgba_r, slot_r[4:0]);
              out_user_r <= 1'b0;
              out_last_r <= 1'b0;
              state_r    <= ST_VERT;
            end
          end
        end
        ST_FLUSH: begin
          if (out_tready) begin
            if (end_r) begin
              out_valid_r <= 1'b0;
              state_r     <= ST_IDLE;
            end else begin
              out_data_r <= vert_data(2'd0, xf_res, px_r, py_r, rgba_r, slot_r[4:0]);
              out_user_r <= 1'b0;
              out_last_r <= 1'b0;
              state_r    <= ST_VERT;
            end
          end
        end
        ST_VERT: begin
          if (out_tready) begin
            if (corner_r == 2'd3) begin
              out_valid_r <= 1'b0;
              state_r     <= ST_IDLE;
            end else begin
              corner_r   <= corner_nxt;
              out_data_r <= vert_data(corner_nxt, xf_res, px_r, py_r, rgba_r,
                                      slot_r[4:0]);
              out_last_r <= (corner_nxt == 2'd3);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `SQB_ASSERT_IMP(a_no_overlap, in_tready, !out_tvalid)
  `SQB_ASSERT_IMP(a_slots_range, 1'b1, (su_r != '0) && (su_r <= SW'(TEXTURE_SLOTS)))
  `SQB_ASSERT_NXT(a_last_to_idle, out_tvalid && out_tready && out_tlast, in_tready)
  `SQB_ASSERT_IMP(a_quads_range, 1'b1, qcnt_r <= CW'(MAX_QUADS))

endmodule

// ===== rtl/sqb_xform.sv =====
// ----------------------------------------------------------------------------
// Sprite quad batcher transform unit
// Computes sine and cosine of the angle and the four size products on one
// shared multiplier under a small step sequencer.
// ----------------------------------------------------------------------------
module sqb_xform (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [14:0]             angle,
  input  logic signed [31:0]      size_x,
  input  logic signed [31:0]      size_y,
  output logic                    done,
  output sqb_pkg::xform_res_t     res
);

  typedef enum logic [1:0] {XS_IDLE, XS_DIV, XS_ISSUE, XS_USE} xstate_t;

  localparam logic [3:0] STEP_TT  = 4'd0;
  localparam logic [3:0] STEP_P9  = 4'd1;
  localparam logic [3:0] STEP_P7  = 4'd2;
  localparam logic [3:0] STEP_P5  = 4'd3;
  localparam logic [3:0] STEP_P3  = 4'd4;
  localparam logic [3:0] STEP_S   = 4'd5;
  localparam logic [3:0] STEP_A   = 4'd6;
  localparam logic [3:0] STEP_B   = 4'd7;
  localparam logic [3:0] STEP_C   = 4'd8;
  localparam logic [3:0] STEP_D   = 4'd9;

  xstate_t             state_r;
  logic [12:0]         r_r;
  logic [30:0]         t_r;
  logic [1:0]          q_r;
  logic [3:0]          step_r;
  logic                which_r;
  logic [30:0]         t2_r;
  logic [31:0]         p_r;
  logic [15:0]         s0_r;
  logic [15:0]         c0_r;
  logic signed [67:0]  prod_r;
  sqb_pkg::xform_res_t res_r;
  logic                done_r;

  logic [14:0]         a_red;
  logic [1:0]          q_in;
  logic [12:0]         r_in;
  logic [12:0]         r_sel;
  logic [36:0]         frac_prod;
  logic [30:0]         t_int;
  logic [30:0]         t_div;
  logic signed [15:0]  sv;
  logic signed [15:0]  cv;
  logic signed [33:0]  ma;
  logic signed [33:0]  mb;
  logic [31:0]         coef;
  logic [33:0]         s_plus;
  logic [15:0]         s_sat;

  always_comb begin
    a_red = (angle >= sqb_pkg::FULL_TURN) ? angle - sqb_pkg::FULL_TURN : angle;
    if (a_red >= 15'(3 * 5760)) begin
      q_in = 2'd3;
      r_in = 13'(a_red - 15'(3 * 5760));
    end else if (a_red >= 15'(2 * 5760)) begin
      q_in = 2'd2;
      r_in = 13'(a_red - 15'(2 * 5760));
    end else if (a_red >= sqb_pkg::QUARTER) begin
      q_in = 2'd1;
      r_in = 13'(a_red - sqb_pkg::QUARTER);
    end else begin
      q_in = 2'd0;
      r_in = a_red[12:0];
    end
  end

  assign r_sel     = which_r ? 13'(sqb_pkg::QUARTER - {2'd0, r_r}) : r_r;
  assign frac_prod = {24'd0, r_sel} * {13'd0, sqb_pkg::RECIP_FRAC};
  assign t_int     = {18'd0, r_sel} * {13'd0, sqb_pkg::RECIP_INT};
  assign t_div     = t_int + {18'd0, frac_prod[36:24]};

  always_comb begin
    case (q_r)
      2'd0:    begin sv = s0_r;            cv = c0_r;            end
      2'd1:    begin sv = c0_r;            cv = 16'(-$signed(s0_r)); end
      2'd2:    begin sv = 16'(-$signed(s0_r)); cv = 16'(-$signed(c0_r)); end
      default: begin sv = 16'(-$signed(c0_r)); cv = s0_r;            end
    endcase
  end

  always_comb begin
    case (step_r)
      STEP_TT: begin ma = {3'b0, t_r};  mb = {3'b0, t_r};        end
      STEP_P9: begin ma = {3'b0, t2_r}; mb = {2'b0, sqb_pkg::C9}; end
      STEP_P7,
      STEP_P5,
      STEP_P3: begin ma = {3'b0, t2_r}; mb = {2'b0, p_r};        end
      STEP_S:  begin ma = {3'b0, t_r};  mb = {2'b0, p_r};        end
      STEP_A:  begin ma = 34'(cv);      mb = 34'(size_x);        end
      STEP_B:  begin ma = 34'(sv);      mb = 34'(size_y);        end
      STEP_C:  begin ma = 34'(sv);      mb = 34'(size_x);        end
      default: begin ma = 34'(cv);      mb = 34'(size_y);        end
    endcase
  end

  always_comb begin
    case (step_r)
      STEP_P9: coef = sqb_pkg::C7;
      STEP_P7: coef = sqb_pkg::C5;
      STEP_P5: coef = sqb_pkg::C3;
      default: coef = sqb_pkg::C1;
    endcase
  end

  assign s_plus = {1'b0, prod_r[62:30]} + 34'd16384;
  assign s_sat  = (s_plus[33:15] > 19'd32767) ? 16'd32767 : s_plus[30:15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= XS_IDLE;
      done_r  <= 1'b0;
      step_r  <= STEP_TT;
      which_r <= 1'b0;
    end else begin
      done_r <= (state_r == XS_USE) && (step_r == STEP_D);
      unique case (state_r)
        XS_IDLE: begin
          if (start) begin
            q_r     <= q_in;
            r_r     <= r_in;
            step_r  <= STEP_TT;
            which_r <= 1'b0;
            state_r <= XS_DIV;
          end
        end
        XS_DIV: begin
          t_r     <= t_div;
          state_r <= XS_ISSUE;
        end
        XS_ISSUE: begin
          prod_r  <= ma * mb;
          state_r <= XS_USE;
        end
        XS_USE: begin
          case (step_r)
            STEP_TT: begin
              t2_r    <= prod_r[60:30];
              step_r  <= step_r + 4'd1;
              state_r <= XS_ISSUE;
            end
            STEP_P9,
            STEP_P7,
            STEP_P5,
            STEP_P3: begin
              p_r     <= coef - prod_r[61:30];
              step_r  <= step_r + 4'd1;
              state_r <= XS_ISSUE;
            end
            STEP_S: begin
              if (which_r) begin
                c0_r    <= s_sat;
                step_r  <= step_r + 4'd1;
                state_r <= XS_ISSUE;
              end else begin
                s0_r    <= s_sat;
                which_r <= 1'b1;
                step_r  <= STEP_TT;
                state_r <= XS_DIV;
              end
            end
            STEP_A: begin
              res_r.a <= prod_r[47:0];
              step_r  <= step_r + 4'd1;
              state_r <= XS_ISSUE;
            end
            STEP_B: begin
              res_r.b <= prod_r[47:0];
              step_r  <= step_r + 4'd1;
              state_r <= XS_ISSUE;
            end
            STEP_C: begin
              res_r.c <= prod_r[47:0];
              step_r  <= step_r + 4'd1;
              state_r <= XS_ISSUE;
            end
            default: begin
              res_r.d <= prod_r[47:0];
              state_r <= XS_IDLE;
            end
          endcase
        end
        default: state_r <= XS_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad batcher testbench
// Sends directed and random sprite items through the stream ports while both
// sides idle at random outside of calm phases. A scoreboard predicts the
// vertex and flush items and checks every output item against them in order.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    bit                kind;
    bit signed [31:0]  pos_x, pos_y, size_x, size_y;
    bit [14:0]         angle;
    bit [7:0]          r, g, b, a;
    bit                use_tex;
    bit [15:0]         tex_id;
  } sprite_t;

  typedef struct packed {
    bit        is_flush;
    bit [10:0] quads;
    bit [31:0] vx, vy;
    bit        u, v;
    bit [31:0] rgba;
    bit [4:0]  slot;
    bit        last;
  } vertex_t;

  localparam int MAX_QUADS = 1024;
  localparam int SLOTS     = 32;

  class quad_scoreboard;
    vertex_t     pending[$];
    bit [15:0]   slot_ids[SLOTS];
    int unsigned slots_used = 1;
    int unsigned quad_count = 0;
    int          errors = 0;

    function automatic longint quarter_sine(longint unsigned r);
      longint unsigned t, t2, p, s;
      t  = (r << 30) / sqb_pkg::QUARTER;
      t2 = (t * t) >> 30;
      p  = sqb_pkg::C9;
      p  = sqb_pkg::C7 - ((t2 * p) >> 30);
      p  = sqb_pkg::C5 - ((t2 * p) >> 30);
      p  = sqb_pkg::C3 - ((t2 * p) >> 30);
      p  = sqb_pkg::C1 - ((t2 * p) >> 30);
      s  = (t * p) >> 30;
      s  = (s + (64'd1 << 14)) >> 15;
      if (s > 32767) s = 32767;
      return longint'(s);
    endfunction

    function automatic vertex_t flush_marker(bit last);
      vertex_t f;
      f = '{default: 0};
      f.is_flush = 1'b1;
      f.quads = quad_count[10:0];
      f.last = last;
      quad_count = 0;
      slots_used = 1;
      return f;
    endfunction

    function void note(sprite_t it);
      int unsigned slot, a, q, rr, k;
      bit found;
      longint s0, c0, sv, cv, hx, hy, dx, dy;
      vertex_t o;
      slot = 0;
      found = 1'b0;
      if (it.kind) begin
        pending.push_back(flush_marker(1'b1));
        return;
      end
      if (it.use_tex)
        for (int i = 1; i < slots_used && i < SLOTS; i++)
          if (!found && slot_ids[i] == it.tex_id) begin
            slot = i;
            found = 1'b1;
          end
      if (quad_count >= MAX_QUADS || (it.use_tex && !found && slots_used >= SLOTS)) begin
        pending.push_back(flush_marker(1'b0));
        found = 1'b0;
        slot = 0;
      end
      if (it.use_tex && !found) begin
        slot = slots_used;
        if (slot < SLOTS) slot_ids[slot] = it.tex_id;
        slots_used++;
      end
      a = 32'(it.angle);
      if (a >= sqb_pkg::FULL_TURN) a -= sqb_pkg::FULL_TURN;
      q = a / sqb_pkg::QUARTER;
      rr = a % sqb_pkg::QUARTER;
      s0 = quarter_sine(rr);
      c0 = quarter_sine(sqb_pkg::QUARTER - rr);
      case (q)
        0: begin sv = s0;  cv = c0;  end
        1: begin sv = c0;  cv = -s0; end
        2: begin sv = -s0; cv = -c0; end
        default: begin sv = -c0; cv = s0; end
      endcase
      for (k = 0; k < 4; k++) begin
        o = '{default: 0};
        o.u = (k == 1 || k == 2);
        o.v = (k >= 2);
        hx = o.u ? longint'(it.size_x) : -longint'(it.size_x);
        hy = o.v ? longint'(it.size_y) : -longint'(it.size_y);
        dx = (cv * hx - sv * hy + 32768) >>> 16;
        dy = (sv * hx + cv * hy + 32768) >>> 16;
        o.vx = 32'(longint'(it.pos_x) + dx);
        o.vy = 32'(longint'(it.pos_y) + dy);
        o.rgba = {it.r, it.g, it.b, it.a};
        o.slot = slot[4:0];
        o.last = (k == 3);
        pending.push_back(o);
      end
      quad_count++;
    endfunction

    task report(string what);
      $display("error at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check(vertex_t got);
      vertex_t e;
      if (pending.size() == 0) begin
        report("output item with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (got != e)
        report({$sformatf("got flush=%0b q=%0d x=%h y=%h uv=%0b%0b c=%h s=%0d l=%0b",
                  got.is_flush, got.quads, got.vx, got.vy, got.u, got.v, got.rgba,
                  got.slot, got.last),
                $sformatf(", want flush=%0b q=%0d x=%h y=%h uv=%0b%0b c=%h s=%0d l=%0b",
                  e.is_flush, e.quads, e.vx, e.vy, e.u, e.v, e.rgba, e.slot, e.last)});
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  quad_scoreboard sb = new();
  bit  send_calm = 1'b0;
  int  cycle = 0;

  sprite_quad_batcher_core u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle <= cycle + 1;

  always @(posedge clk) begin
    vertex_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.quads    = out_tdata[10:0];
      got.vx       = out_tdata[42:11];
      got.vy       = out_tdata[74:43];
      got.u        = out_tdata[75];
      got.v        = out_tdata[76];
      got.rgba     = out_tdata[108:77];
      got.slot     = out_tdata[113:109];
      got.is_flush = out_tuser;
      got.last     = out_tlast;
      sb.check(got);
    end
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (cycle == 3000) hold = 2500;
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (cycle > 8000 && cycle < 20000) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 11);
      end
    end
  end

  task send(sprite_t it);
    while (!send_calm && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {it.tex_id, it.use_tex, it.a, it.b, it.g, it.r, it.angle,
                  it.size_y, it.size_x, it.pos_y, it.pos_x};
    do @(posedge clk); while (!in_tready);
    sb.note(it);
  endtask

  function automatic sprite_t plain_quad();
    sprite_t it;
    it.kind = 1'b0;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.size_x = $urandom;
    it.size_y = $urandom;
    it.angle = 15'($urandom_range(23039));
    it.r = 8'($urandom); it.g = 8'($urandom); it.b = 8'($urandom); it.a = 8'($urandom);
    it.use_tex = 1'b0;
    it.tex_id = 16'($urandom);
    return it;
  endfunction

  function automatic sprite_t scene_end();
    sprite_t it;
    it = plain_quad();
    it.kind = 1'b1;
    return it;
  endfunction

  function automatic sprite_t random_item();
    sprite_t it;
    int sel;
    it = plain_quad();
    sel = $urandom_range(99);
    if (sel < 5) it.kind = 1'b1;
    if ($urandom_range(9) == 0) it.angle = 15'($urandom_range(32767));
    if ($urandom_range(3) == 0) begin
      it.size_x = $signed(32'($urandom_range(8 << 16)));
      it.size_y = -$signed(32'($urandom_range(8 << 16)));
    end
    it.use_tex = ($urandom_range(9) < 7);
    it.tex_id = ($urandom_range(1) == 0) ? 16'($urandom_range(40)) : 16'($urandom);
    return it;
  endfunction

  initial begin
    sprite_t it;
    int angles[7];
    angles = '{0, 5760, 11520, 17280, 23039, 23040, 32767};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(scene_end());
    foreach (angles[i]) begin
      it = plain_quad();
      it.angle = 15'(angles[i]);
      it.pos_x = (i % 2) ? 32'h7fffffff : 32'h80000000;
      it.pos_y = (i % 2) ? 32'h80000000 : 32'h7fffffff;
      it.size_x = (i % 3 == 0) ? 32'h7fffffff : 32'h80000000;
      it.size_y = (i % 3 == 1) ? 32'h7fffffff : 32'h80000000;
      {it.r, it.g, it.b, it.a} = (i % 2) ? 32'hffffffff : 32'h0;
      it.use_tex = 1'(i % 2);
      it.tex_id = (i < 4) ? 16'h0000 : 16'hffff;
      send(it);
    end
    for (int i = 0; i < 34; i++) begin
      it = plain_quad();
      it.use_tex = 1'b1;
      it.tex_id = 16'(i * 7 + 100);
      send(it);
    end
    send(scene_end());
    send(scene_end());

    send_calm = 1'b1;
    for (int i = 0; i < 150; i++) send(random_item());
    send_calm = 1'b0;

    for (int i = 0; i < 306; i++) send(random_item());
    in_tvalid <= 1'b0;

    wait (sb.pending.size() == 0);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sqb_pkg.sv
rtl/sqb_xform.sv
rtl/sprite_quad_batcher_core.sv
tb/tb.sv
